[src/lsdc_pkg.sv]
// Shared types, codes and calendar helper functions for the lunar/solar date converter.
package lsdc_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RANGE   = 2'd2,
        ST_LOADED  = 2'd3
    } status_t;

    // Item kinds; the fourth code is answered as an invalid date.
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_S2L  = 2'd1;
    localparam logic [1:0] KIND_L2S  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_FIRST = 1'b0;
    localparam logic CFG_LAST  = 1'b1;

    localparam logic [11:0] FIRST_YEAR_RST = 12'd1901;
    localparam logic [11:0] LAST_YEAR_RST  = 12'd2099;

    // floor(y / 100) equals (y * 5243) >> 19 for every 13-bit y used here.
    localparam logic [12:0] DIV100_MUL = 13'd5243;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_VALID,
        S_PREV,
        S_FWD,
        S_BWD,
        S_LSUM,
        S_YLEN,
        S_YWAIT,
        S_MWALK,
        S_WEEK,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    wr_table;
        logic    ana_year;
        logic    load_w;
        logic    rd_prev;
        logic    init_fwd;
        logic    step_fwd;
        logic    res_fwd;
        logic    init_bwd;
        logic    load_prev;
        logic    step_bwd;
        logic    res_bwd;
        logic    init_lsum;
        logic    step_lsum;
        logic    roll_year;
        logic    step_mwalk;
        logic    res_solar;
        logic    calc_wd;
        logic    set_status;
        status_t status;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       intab;
        logic       conv;
        logic       date_ok;
        logic       before_ny;
        logic       idx_zero;
        logic       fwd_done;
        logic       bwd_done;
        logic       lsum_done;
        logic       year_over;
        logic       mwalk_done;
        logic       out_free;
    } stat_t;

    function automatic logic [3:0] leap_of(input logic [23:0] w);
        logic [3:0] l;
        l = w[23:20];
        if (l >= 4'd1 && l <= 4'd12) begin
            return l;
        end
        return 4'd0;
    endfunction

    // Day offset of lunar new year from January 1.
    function automatic logic [5:0] ny_offset(input logic [23:0] w);
        logic [5:0] base;
        logic [4:0] dd;
        base = (w[6:5] == 2'd2) ? 6'd31 : 6'd0;
        dd   = (w[4:0] != 5'd0) ? (w[4:0] - 5'd1) : 5'd0;
        return base + {1'b0, dd};
    endfunction

    function automatic logic [4:0] slot_len(input logic [23:0] w, input logic [3:0] s);
        logic b;
        b = 1'b0;
        if (s >= 4'd1 && s <= 4'd13) begin
            b = w[5'd20 - {1'b0, s}];
        end
        return b ? 5'd30 : 5'd29;
    endfunction

    function automatic logic [3:0] slot_month(input logic [3:0] leap, input logic [3:0] s);
        return (leap != 4'd0 && s > leap) ? (s - 4'd1) : s;
    endfunction

    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] c;
        case (m)
            4'd0:    c = 9'd0;
            4'd1:    c = 9'd31;
            4'd2:    c = 9'd59;
            4'd3:    c = 9'd90;
            4'd4:    c = 9'd120;
            4'd5:    c = 9'd151;
            4'd6:    c = 9'd181;
            4'd7:    c = 9'd212;
            4'd8:    c = 9'd243;
            4'd9:    c = 9'd273;
            4'd10:   c = 9'd304;
            4'd11:   c = 9'd334;
            4'd12:   c = 9'd365;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd2:                       len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [2:0] wd_month(input logic [3:0] m);
        logic [2:0] v;
        case (m)
            4'd1:    v = 3'd0;
            4'd2:    v = 3'd3;
            4'd3:    v = 3'd3;
            4'd4:    v = 3'd6;
            4'd5:    v = 3'd1;
            4'd6:    v = 3'd4;
            4'd7:    v = 3'd6;
            4'd8:    v = 3'd2;
            4'd9:    v = 3'd5;
            4'd10:   v = 3'd0;
            4'd11:   v = 3'd3;
            4'd12:   v = 3'd5;
            default: v = 3'd0;
        endcase
        return v;
    endfunction

    // Since 8 is 1 modulo 7, summing octal digits keeps the residue.
    function automatic logic [2:0] mod7(input logic [12:0] n);
        logic [5:0] s1;
        logic [3:0] s2;
        s1 = 6'(n[2:0]) + 6'(n[5:3]) + 6'(n[8:6]) + 6'(n[11:9]) + 6'(n[12]);
        s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
        return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
    endfunction

endpackage

[src/lunar_solar_date_converter.sv]
// Top level of the lunar/solar date converter: controller and datapath.
//
//  Channel   Direction  Handshake             Carries
//  s_        in         s_valid / s_ready     kind, year, month, day, table word
//  m_        out        m_valid / m_ready     status, year, month, day, weekday
//  cfg_      in         cfg_valid / cfg_ready register index and 12-bit data
//
// A load, or an item rejected at the check, goes from the check state straight to the finish state.
// The length of a conversion is set by the month-slot walk, which steps one
// slot per cycle, and for lunar to solar also by the Gregorian month walk.
// Reset (aresetn low, synchronous) returns the sequencer to idle and the year limits
// to 1901 and 2099; the year table is not cleared.
// A new input beat is taken as soon as the sequencer is idle, while an earlier
// result may still wait in the output register for m_ready.
module lunar_solar_date_converter #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [11:0] s_year,
    input  logic [3:0]  s_month,
    input  logic [4:0]  s_day,
    input  logic [23:0] s_table_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [11:0] m_out_year,
    output logic [3:0]  m_out_month,
    output logic [4:0]  m_out_day,
    output logic [2:0]  m_weekday,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data
);

    lsdc_pkg::cmd_t  cmd;
    lsdc_pkg::stat_t st;

    lsdc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    lsdc_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_kind       (s_kind),
        .s_year       (s_year),
        .s_month      (s_month),
        .s_day        (s_day),
        .s_table_word (s_table_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_out_year   (m_out_year),
        .m_out_month  (m_out_month),
        .m_out_day    (m_out_day),
        .m_weekday    (m_weekday),
        .cmd          (cmd),
        .st           (st)
    );

endmodule

[src/lsdc_ctrl.sv]
// Sequencing state machine of the lunar/solar date converter.
module lsdc_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  lsdc_pkg::stat_t st,
    output lsdc_pkg::cmd_t  cmd
);

    lsdc_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lsdc_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = lsdc_pkg::ST_OK;
        s_ready    = 1'b0;
        case (state_reg)
            lsdc_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = lsdc_pkg::S_CHECK;
                end
            end
            lsdc_pkg::S_CHECK: begin
                case (st.kind)
                    lsdc_pkg::KIND_LOAD: begin
                        cmd.wr_table   = st.intab;
                        cmd.set_status = 1'b1;
                        cmd.status     = st.intab ? lsdc_pkg::ST_LOADED : lsdc_pkg::ST_RANGE;
                        state_next     = lsdc_pkg::S_FINISH;
                    end
                    lsdc_pkg::KIND_S2L, lsdc_pkg::KIND_L2S: begin
                        if (!st.conv) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = lsdc_pkg::ST_RANGE;
                            state_next     = lsdc_pkg::S_FINISH;
                        end else begin
                            cmd.ana_year = 1'b1;
                            state_next   = lsdc_pkg::S_READ;
                        end
                    end
                    default: begin
                        cmd.set_status = 1'b1;
                        cmd.status     = lsdc_pkg::ST_INVALID;
                        state_next     = lsdc_pkg::S_FINISH;
                    end
                endcase
            end
            lsdc_pkg::S_READ: begin
                cmd.load_w = 1'b1;
                state_next = lsdc_pkg::S_VALID;
            end
            lsdc_pkg::S_VALID: begin
                if (!st.date_ok) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = lsdc_pkg::ST_INVALID;
                    state_next     = lsdc_pkg::S_FINISH;
                end else if (st.kind == lsdc_pkg::KIND_S2L) begin
                    if (!st.before_ny) begin
                        cmd.init_fwd = 1'b1;
                        state_next   = lsdc_pkg::S_FWD;
                    end else if (st.idx_zero) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = lsdc_pkg::ST_RANGE;
                        state_next     = lsdc_pkg::S_FINISH;
                    end else begin
                        cmd.rd_prev  = 1'b1;
                        cmd.init_bwd = 1'b1;
                        state_next   = lsdc_pkg::S_PREV;
                    end
                end else begin
                    cmd.init_lsum = 1'b1;
                    state_next    = lsdc_pkg::S_LSUM;
                end
            end
            lsdc_pkg::S_PREV: begin
                cmd.load_prev = 1'b1;
                state_next    = lsdc_pkg::S_BWD;
            end
            lsdc_pkg::S_FWD: begin
                if (st.fwd_done) begin
                    cmd.res_fwd = 1'b1;
                    state_next  = lsdc_pkg::S_WEEK;
                end else begin
                    cmd.step_fwd = 1'b1;
                end
            end
            lsdc_pkg::S_BWD: begin
                if (st.bwd_done) begin
                    cmd.res_bwd = 1'b1;
                    state_next  = lsdc_pkg::S_WEEK;
                end else begin
                    cmd.step_bwd = 1'b1;
                end
            end
            lsdc_pkg::S_LSUM: begin
                if (st.lsum_done) begin
                    state_next = lsdc_pkg::S_YLEN;
                end else begin
                    cmd.step_lsum = 1'b1;
                end
            end
            lsdc_pkg::S_YLEN: begin
                cmd.roll_year = 1'b1;
                state_next    = lsdc_pkg::S_YWAIT;
            end
            lsdc_pkg::S_YWAIT: begin
                // The year analysis of the rolled year settles during this cycle.
                if (st.year_over) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = lsdc_pkg::ST_RANGE;
                    state_next     = lsdc_pkg::S_FINISH;
                end else begin
                    state_next = lsdc_pkg::S_MWALK;
                end
            end
            lsdc_pkg::S_MWALK: begin
                if (st.mwalk_done) begin
                    cmd.res_solar = 1'b1;
                    state_next    = lsdc_pkg::S_WEEK;
                end else begin
                    cmd.step_mwalk = 1'b1;
                end
            end
            lsdc_pkg::S_WEEK: begin
                cmd.calc_wd    = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status     = lsdc_pkg::ST_OK;
                state_next     = lsdc_pkg::S_FINISH;
            end
            lsdc_pkg::S_FINISH: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = lsdc_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = lsdc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[src/lsdc_dp.sv]
// Datapath of the lunar/solar date converter: year table, walk counters and result register.
module lsdc_dp #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [1:0]       s_kind,
    input  logic [11:0]      s_year,
    input  logic [3:0]       s_month,
    input  logic [4:0]       s_day,
    input  logic [23:0]      s_table_word,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [11:0]      cfg_data,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_status,
    output logic [11:0]      m_out_year,
    output logic [3:0]       m_out_month,
    output logic [4:0]       m_out_day,
    output logic [2:0]       m_weekday,
    input  lsdc_pkg::cmd_t   cmd,
    output lsdc_pkg::stat_t  st
);

    localparam int          IDXW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [12:0] DEPTH13 = 13'(TABLE_DEPTH);

    // Captured item and configuration.
    logic [1:0]  kind_reg;
    logic [11:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic [23:0] tword_reg;
    logic [11:0] first_reg;
    logic [11:0] last_reg;

    logic [23:0] year_table_reg [TABLE_DEPTH];
    logic [23:0] rdata_reg;
    logic [23:0] w_reg;

    // Year analysis unit: quotient by 100 of the year under study.
    logic [12:0] ay_reg;
    logic [6:0]  q100_reg;

    logic [8:0]  acc_reg;
    logic [3:0]  slot_reg;
    logic [3:0]  tgt_reg;
    logic [3:0]  leap_reg;

    lsdc_pkg::status_t res_status_reg;
    logic [11:0] res_year_reg;
    logic [3:0]  res_month_reg;
    logic [4:0]  res_day_reg;
    logic [12:0] wsum_reg;

    logic        m_valid_reg;
    logic [1:0]  out_status_reg;
    logic [11:0] out_year_reg;
    logic [3:0]  out_month_reg;
    logic [4:0]  out_day_reg;
    logic [2:0]  out_wd_reg;

    logic [12:0]     diff;
    logic            intab;
    logic [IDXW-1:0] idx;
    logic [IDXW-1:0] rd_addr;
    logic [25:0]     prod;
    logic [12:0]     q_x100;
    logic [12:0]     r100;
    logic            ay_hund;
    logic            leap_ay;
    logic            mon_ok;
    logic            greg_ok;
    logic [8:0]      doy;
    logic [8:0]      spring;
    logic [3:0]      lp_w;
    logic [3:0]      tslot;
    logic            lunar_ok;
    logic [3:0]      nslots;
    logic [4:0]      cur_len;
    logic [4:0]      mlen_cur;
    logic [8:0]      ylen;
    logic [12:0]     y1;
    logic [6:0]      q1;
    logic [12:0]     base;
    logic [3:0]      wk_m;
    logic [4:0]      wk_d;
    logic [12:0]     wsum;
    logic [9:0]      fwd_day;
    logic [8:0]      bwd_day;

    assign cfg_ready = 1'b1;

    always_comb begin
        diff    = {1'b0, year_reg} - {1'b0, first_reg};
        intab   = (year_reg >= first_reg) && (diff < DEPTH13);
        idx     = diff[IDXW-1:0];
        rd_addr = cmd.rd_prev ? (idx - IDXW'(1)) : idx;

        prod    = 26'(ay_reg) * 26'(lsdc_pkg::DIV100_MUL);
        q_x100  = (13'(q100_reg) << 6) + (13'(q100_reg) << 5) + (13'(q100_reg) << 2);
        r100    = ay_reg - q_x100;
        ay_hund = (r100 == 13'd0);
        leap_ay = ((ay_reg[1:0] == 2'd0) && !ay_hund) || (ay_hund && (q100_reg[1:0] == 2'd0));

        mon_ok  = (month_reg >= 4'd1) && (month_reg <= 4'd12);
        greg_ok = mon_ok && (day_reg != 5'd0) &&
                  (day_reg <= lsdc_pkg::month_len(month_reg, leap_ay));
        doy     = lsdc_pkg::cum_days(month_reg - 4'd1) + {4'd0, day_reg} - 9'd1 +
                  {8'd0, (leap_ay && month_reg > 4'd2)};
        spring  = {3'd0, lsdc_pkg::ny_offset(w_reg)};

        // A month equal to the leap month names the regular month.
        lp_w     = lsdc_pkg::leap_of(w_reg);
        tslot    = (mon_ok && lp_w != 4'd0 && month_reg > lp_w) ? (month_reg + 4'd1) : month_reg;
        lunar_ok = mon_ok && (day_reg != 5'd0) && (day_reg <= lsdc_pkg::slot_len(w_reg, tslot));

        nslots   = (leap_reg != 4'd0) ? 4'd13 : 4'd12;
        cur_len  = lsdc_pkg::slot_len(w_reg, slot_reg);
        mlen_cur = lsdc_pkg::month_len(slot_reg, leap_ay);
        ylen     = leap_ay ? 9'd366 : 9'd365;

        // Year zero leaves the prior-year terms at a fixed residue of two.
        y1   = ay_reg - 13'd1;
        q1   = q100_reg - {6'd0, ay_hund};
        base = y1 + (y1 >> 2) - 13'(q1) + 13'(q1 >> 2);
        wk_m = (kind_reg == lsdc_pkg::KIND_S2L) ? month_reg : res_month_reg;
        wk_d = (kind_reg == lsdc_pkg::KIND_S2L) ? day_reg : res_day_reg;
        wsum = ((ay_reg == 13'd0) ? 13'd2 : base) + 13'(lsdc_pkg::wd_month(wk_m)) +
               13'(wk_d) + 13'(leap_ay && wk_m > 4'd2);

        fwd_day = {1'b0, acc_reg} + 10'd1;
        bwd_day = {4'd0, cur_len} - acc_reg + 9'd1;

        st.kind       = kind_reg;
        st.intab      = intab;
        st.conv       = intab && (year_reg <= last_reg);
        st.date_ok    = (kind_reg == lsdc_pkg::KIND_S2L) ? greg_ok : lunar_ok;
        st.before_ny  = doy < spring;
        st.idx_zero   = (idx == '0);
        st.fwd_done   = !((slot_reg < nslots) && (acc_reg >= {4'd0, cur_len}));
        st.bwd_done   = !((slot_reg > 4'd1) && (acc_reg > {4'd0, cur_len}));
        st.lsum_done  = (slot_reg >= tgt_reg);
        st.year_over  = ay_reg[12];
        st.mwalk_done = !((slot_reg < 4'd12) && (acc_reg > {4'd0, mlen_cur}));
        st.out_free   = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= lsdc_pkg::FIRST_YEAR_RST;
            last_reg  <= lsdc_pkg::LAST_YEAR_RST;
        end else if (cfg_valid) begin
            if (cfg_index == lsdc_pkg::CFG_FIRST) begin
                first_reg <= cfg_data;
            end else if (cfg_index == lsdc_pkg::CFG_LAST) begin
                last_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_table) begin
            year_table_reg[idx] <= tword_reg;
        end
        rdata_reg <= year_table_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg  <= s_kind;
            year_reg  <= s_year;
            month_reg <= s_month;
            day_reg   <= s_day;
            tword_reg <= s_table_word;
        end

        if (cmd.ana_year) begin
            ay_reg <= {1'b0, year_reg};
        end else if (cmd.roll_year && acc_reg > ylen) begin
            ay_reg <= ay_reg + 13'd1;
        end
        q100_reg <= prod[25:19];

        if (cmd.load_w || cmd.load_prev) begin
            w_reg <= rdata_reg;
        end

        if (cmd.init_fwd) begin
            leap_reg <= lp_w;
        end else if (cmd.load_prev) begin
            leap_reg <= lsdc_pkg::leap_of(rdata_reg);
        end

        if (cmd.init_fwd || cmd.init_lsum || cmd.roll_year) begin
            slot_reg <= 4'd1;
        end else if (cmd.load_prev) begin
            slot_reg <= (lsdc_pkg::leap_of(rdata_reg) != 4'd0) ? 4'd13 : 4'd12;
        end else if (cmd.step_fwd || cmd.step_lsum || cmd.step_mwalk) begin
            slot_reg <= slot_reg + 4'd1;
        end else if (cmd.step_bwd) begin
            slot_reg <= slot_reg - 4'd1;
        end

        if (cmd.init_lsum) begin
            tgt_reg <= tslot;
        end

        if (cmd.init_fwd) begin
            acc_reg <= doy - spring;
        end else if (cmd.init_bwd) begin
            acc_reg <= spring - doy;
        end else if (cmd.init_lsum) begin
            acc_reg <= {3'd0, lsdc_pkg::ny_offset(w_reg)} + {4'd0, day_reg};
        end else if (cmd.step_fwd || cmd.step_bwd) begin
            acc_reg <= acc_reg - {4'd0, cur_len};
        end else if (cmd.step_lsum) begin
            acc_reg <= acc_reg + {4'd0, cur_len};
        end else if (cmd.roll_year) begin
            if (acc_reg > ylen) begin
                acc_reg <= acc_reg - ylen;
            end
        end else if (cmd.step_mwalk) begin
            acc_reg <= acc_reg - {4'd0, mlen_cur};
        end

        if (cmd.res_fwd) begin
            res_year_reg  <= year_reg;
            res_month_reg <= lsdc_pkg::slot_month(leap_reg, slot_reg);
            res_day_reg   <= (fwd_day > 10'd31) ? 5'd31 : fwd_day[4:0];
        end else if (cmd.res_bwd) begin
            res_year_reg  <= year_reg - 12'd1;
            res_month_reg <= lsdc_pkg::slot_month(leap_reg, slot_reg);
            res_day_reg   <= (acc_reg > {4'd0, cur_len}) ? 5'd1 : bwd_day[4:0];
        end else if (cmd.res_solar) begin
            res_year_reg  <= ay_reg[11:0];
            res_month_reg <= slot_reg;
            res_day_reg   <= acc_reg[4:0];
        end

        if (cmd.calc_wd) begin
            wsum_reg <= wsum;
        end
        if (cmd.set_status) begin
            res_status_reg <= cmd.status;
        end

        // Fields other than status read zero unless the conversion succeeded.
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            if (res_status_reg == lsdc_pkg::ST_OK) begin
                out_year_reg  <= res_year_reg;
                out_month_reg <= res_month_reg;
                out_day_reg   <= res_day_reg;
                out_wd_reg    <= lsdc_pkg::mod7(wsum_reg);
            end else begin
                out_year_reg  <= 12'd0;
                out_month_reg <= 4'd0;
                out_day_reg   <= 5'd0;
                out_wd_reg    <= 3'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = out_status_reg;
    assign m_out_year  = out_year_reg;
    assign m_out_month = out_month_reg;
    assign m_out_day   = out_day_reg;
    assign m_weekday   = out_wd_reg;

endmodule

[src/lsdc_checker.sv]
// Port-level assertions for the lunar/solar date converter and their bind.
module lsdc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_kind,
    input logic [11:0] s_year,
    input logic [3:0]  s_month,
    input logic [4:0]  s_day,
    input logic [23:0] s_table_word,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [11:0] m_out_year,
    input logic [3:0]  m_out_month,
    input logic [4:0]  m_out_day,
    input logic [2:0]  m_weekday,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        cfg_index,
    input logic [11:0] cfg_data
);

    // Items taken in but whose result beat has not yet gone out.
    logic [2:0] pend_reg, pend_next;

    always_comb begin
        pend_next = pend_reg + 3'(s_valid && s_ready) - 3'(m_valid && m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 3'd0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_out_year) &&
        $stable(m_out_month) && $stable(m_out_day) && $stable(m_weekday))
        else $error("stalled result beat changed");

    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != lsdc_pkg::ST_OK |->
        m_out_year == 12'd0 && m_out_month == 4'd0 && m_out_day == 5'd0 && m_weekday == 3'd0)
        else $error("non-converted result carries a date");

    a_ok_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == lsdc_pkg::ST_OK |->
        m_out_month >= 4'd1 && m_out_month <= 4'd12 && m_out_day >= 5'd1 && m_weekday <= 3'd6)
        else $error("converted date out of range");

    a_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= 3'd2 && !(pend_reg == 3'd0 && m_valid))
        else $error("result count does not match input count");

endmodule

bind lunar_solar_date_converter lsdc_checker u_lsdc_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the lunar/solar date converter with its own calendar predictor.
module testbench;
    import lsdc_pkg::*;

    localparam int TB_DEPTH      = 256;
    localparam int SETTLE_CYCLES = 40;
    localparam int SHOW_LIMIT    = 10;
    localparam int TIMEOUT_NS    = 8000000;
    localparam int MAX_YEAR      = 4095;

    // The fourth kind code has no name in the package; the block answers it as invalid.
    localparam logic [1:0] KIND_SPARE = 2'd3;

    // Year words for the directed cases.
    localparam logic [23:0] W_LEAP4 = {4'd4, 13'b1011010101101, 2'd1, 5'd22};
    localparam logic [23:0] W_FEB8  = {4'd0, 13'b0101101011010, 2'd2, 5'd8};
    localparam logic [23:0] W_ODD   = {4'd14, 13'b1111000011110, 2'd0, 5'd0};
    localparam logic [23:0] W_SHORT = {4'd0, 13'd0, 2'd1, 5'd1};
    localparam logic [23:0] W_ALL   = 24'hFFFFFF;
    localparam logic [23:0] W_LATE  = {4'd6, 13'h1FFF, 2'd2, 5'd20};

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  wday;
    } date_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = '0;
    logic [11:0] s_year = '0;
    logic [3:0]  s_month = '0;
    logic [4:0]  s_day = '0;
    logic [23:0] s_table_word = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [11:0] m_out_year;
    logic [3:0]  m_out_month;
    logic [4:0]  m_out_day;
    logic [2:0]  m_weekday;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [11:0] cfg_data = '0;

    // Predictor state: its own copy of the year table and of the year limits.
    date_res_t   expected_dates[$];
    logic [23:0] lunar_table [TB_DEPTH];
    bit          table_loaded [TB_DEPTH];
    int          first_year = FIRST_YEAR_RST;
    int          last_year = LAST_YEAR_RST;

    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int fail_count = 0;

    lunar_solar_date_converter #(.TABLE_DEPTH(TB_DEPTH)) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_kind(s_kind),
        .s_year(s_year),
        .s_month(s_month),
        .s_day(s_day),
        .s_table_word(s_table_word),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_out_year(m_out_year),
        .m_out_month(m_out_month),
        .m_out_day(m_out_day),
        .m_weekday(m_weekday),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    initial begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

    function automatic bit is_leap_year(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int days_in_month(input int y, input int m);
        case (m)
            2: return is_leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default: return 31;
        endcase
    endfunction

    // Day number within the year, January 1 being day 1.
    function automatic int day_of_year(input int y, input int m, input int d);
        int n;
        int i;
        n = d;
        for (i = 1; i < m; i++) n += days_in_month(y, i);
        return n;
    endfunction

    // Proleptic Gregorian count where January 1 of year 1 is a Monday.
    function automatic int weekday_on(input int y, input int m, input int d);
        int y1;
        y1 = y - 1;
        return (y1 + y1 / 4 - y1 / 100 + y1 / 400 + day_of_year(y, m, d)) % 7;
    endfunction

    function automatic int moon_len(input logic [23:0] w, input int s);
        return w[20 - s] ? 30 : 29;
    endfunction

    function automatic int leap_number(input logic [23:0] w);
        int l;
        l = w[23:20];
        return (l >= 1 && l <= 12) ? l : 0;
    endfunction

    // Days from January 1 to lunar new year.
    function automatic int new_year_gap(input logic [23:0] w);
        int dd;
        dd = w[4:0];
        return ((w[6:5] == 2'd2) ? 31 : 0) + ((dd != 0) ? dd - 1 : 0);
    endfunction

    function automatic int month_of_slot(input int lp, input int s);
        return (lp != 0 && s > lp) ? s - 1 : s;
    endfunction

    function automatic date_res_t predict_date(input logic [1:0] kind, input int y, input int m,
                                               input int d, input logic [23:0] word);
        date_res_t   r;
        logic [23:0] w;
        logic [23:0] pw;
        int          idx;
        int          lp;
        int          s;
        int          i;
        int          rem;
        int          back;
        int          doy;
        int          ny;
        int          now;
        int          ylen;
        int          sy;
        int          sm;
        bit          in_tab;
        bit          conv;
        bit          done;
        r = '0;
        r.status = ST_INVALID;
        done = 1'b0;
        in_tab = (y >= first_year) && (y - first_year < TB_DEPTH);
        idx = y - first_year;
        conv = in_tab && (y <= last_year);
        if (kind == KIND_LOAD) begin
            if (in_tab) begin
                lunar_table[idx] = word;
                table_loaded[idx] = 1'b1;
                r.status = ST_LOADED;
            end else begin
                r.status = ST_RANGE;
            end
        end else if (kind == KIND_S2L) begin
            if (!conv) begin
                r.status = ST_RANGE;
            end else if (m < 1 || m > 12 || d < 1 || d > days_in_month(y, m)) begin
                r.status = ST_INVALID;
            end else begin
                w = lunar_table[idx];
                doy = day_of_year(y, m, d) - 1;
                ny = new_year_gap(w);
                if (doy >= ny) begin
                    // Walk forward from new year; the last slot absorbs any excess.
                    lp = leap_number(w);
                    rem = doy - ny;
                    s = 1;
                    while (s < ((lp != 0) ? 13 : 12) && rem >= moon_len(w, s)) begin
                        rem -= moon_len(w, s);
                        s++;
                    end
                    r.year = y;
                    r.month = month_of_slot(lp, s);
                    r.day = (rem + 1 > 31) ? 31 : rem + 1;
                    done = 1'b1;
                end else if (idx == 0) begin
                    r.status = ST_RANGE;
                end else begin
                    // Walk backward from the end of the previous lunar year.
                    pw = lunar_table[idx - 1];
                    lp = leap_number(pw);
                    s = (lp != 0) ? 13 : 12;
                    back = ny - doy;
                    while (s > 1 && back > moon_len(pw, s)) begin
                        back -= moon_len(pw, s);
                        s--;
                    end
                    r.year = y - 1;
                    r.month = month_of_slot(lp, s);
                    r.day = (back > moon_len(pw, s)) ? 1 : moon_len(pw, s) - back + 1;
                    done = 1'b1;
                end
                if (done) begin
                    r.status = ST_OK;
                    r.wday = weekday_on(y, m, d);
                end
            end
        end else if (kind == KIND_L2S) begin
            if (!conv) begin
                r.status = ST_RANGE;
            end else begin
                w = lunar_table[idx];
                lp = leap_number(w);
                s = (m >= 1 && m <= 12 && lp != 0 && m > lp) ? m + 1 : m;
                if (m < 1 || m > 12 || d < 1 || d > moon_len(w, s)) begin
                    r.status = ST_INVALID;
                end else begin
                    now = new_year_gap(w) + d;
                    for (i = 1; i < s; i++) now += moon_len(w, i);
                    sy = y;
                    ylen = is_leap_year(sy) ? 366 : 365;
                    if (now > ylen) begin
                        now -= ylen;
                        sy++;
                    end
                    if (sy > MAX_YEAR) begin
                        r.status = ST_RANGE;
                    end else begin
                        sm = 1;
                        while (sm < 12 && now > days_in_month(sy, sm)) begin
                            now -= days_in_month(sy, sm);
                            sm++;
                        end
                        r.status = ST_OK;
                        r.year = sy;
                        r.month = sm;
                        r.day = now;
                        r.wday = weekday_on(sy, sm, now);
                    end
                end
            end
        end
        return r;
    endfunction

    // A conversion may read its own entry and the one before it; both must hold a word.
    function automatic bit read_is_safe(input int y);
        int idx;
        if (y < first_year || y - first_year >= TB_DEPTH) return 1'b1;
        idx = y - first_year;
        return table_loaded[idx] && (idx == 0 || table_loaded[idx - 1]);
    endfunction

    // Year word with a plausible new year date and leap month.
    function automatic logic [23:0] plausible_year_word();
        logic [3:0]  lp;
        logic [12:0] lengths;
        logic [1:0]  code;
        logic [4:0]  dd;
        lp = ($urandom_range(2) == 0) ? 4'($urandom_range(1, 12)) : 4'd0;
        lengths = 13'($urandom);
        if ($urandom_range(1) == 0) begin
            code = 2'd1;
            dd = 5'($urandom_range(21, 31));
        end else begin
            code = 2'd2;
            dd = 5'($urandom_range(1, 20));
        end
        return {lp, lengths, code, dd};
    endfunction

    task automatic send_item(input logic [1:0] kind, input int year, input int month,
                             input int day, input logic [23:0] word);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_year <= 12'(year);
        s_month <= 4'(month);
        s_day <= 5'(day);
        s_table_word <= word;
        do @(posedge aclk); while (!s_ready);
        expected_dates.push_back(predict_date(kind, year & 12'hFFF, month & 4'hF, day & 5'h1F,
                                              word));
    endtask

    task automatic pause_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_dates.size() != 0);
    endtask

    // Both registers are written back to back; valid stays high across the two beats.
    task automatic write_limits(input int first, input int last);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_FIRST;
        cfg_data <= 12'(first);
        do @(posedge aclk); while (!cfg_ready);
        first_year = first;
        cfg_index <= CFG_LAST;
        cfg_data <= 12'(last);
        do @(posedge aclk); while (!cfg_ready);
        last_year = last;
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin : result_check
        date_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_dates.size() == 0) begin
                fail_count++;
                if (fail_count <= SHOW_LIMIT)
                    $display("unexpected result beat: status %0d date %0d-%0d-%0d weekday %0d",
                             m_status, m_out_year, m_out_month, m_out_day, m_weekday);
            end else begin
                want = expected_dates.pop_front();
                if (m_status !== want.status || m_out_year !== want.year ||
                    m_out_month !== want.month || m_out_day !== want.day ||
                    m_weekday !== want.wday) begin
                    fail_count++;
                    if (fail_count <= SHOW_LIMIT)
                        $display({"mismatch: expected status %0d date %0d-%0d-%0d weekday %0d,",
                                  " got status %0d date %0d-%0d-%0d weekday %0d"},
                                 want.status, want.year, want.month, want.day, want.wday,
                                 m_status, m_out_year, m_out_month, m_out_day, m_weekday);
                end
            end
        end
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Runs on the limits left by reset, so it also checks their reset values.
    task automatic test_reset_limits();
        send_item(KIND_LOAD, 1900, 1, 1, W_FEB8);
        send_item(KIND_LOAD, 1901, 1, 1, W_LEAP4);
        send_item(KIND_LOAD, 1902, 1, 1, W_FEB8);
        send_item(KIND_LOAD, 2099, 1, 1, W_ALL);
        send_item(KIND_LOAD, 2100, 1, 1, W_FEB8);
        send_item(KIND_LOAD, 2157, 1, 1, W_ALL);
        send_item(KIND_S2L, 2100, 6, 15, 24'd0);
        send_item(KIND_S2L, 2099, 12, 31, 24'd0);
        send_item(KIND_S2L, 1901, 1, 5, 24'd0);
    endtask

    task automatic test_directed_cases();
        send_item(KIND_LOAD, 1903, 1, 1, W_ODD);
        send_item(KIND_LOAD, 1904, 1, 1, W_SHORT);
        send_item(KIND_S2L, 1902, 1, 15, 24'd0);
        send_item(KIND_S2L, 1902, 2, 8, 24'd0);
        send_item(KIND_S2L, 1904, 12, 31, 24'd0);
        send_item(KIND_S2L, 1904, 2, 29, 24'd0);
        send_item(KIND_S2L, 1903, 2, 29, 24'd0);
        send_item(KIND_S2L, 1902, 4, 31, 24'd0);
        send_item(KIND_S2L, 1902, 0, 10, 24'd0);
        send_item(KIND_S2L, 1902, 5, 0, 24'd0);
        send_item(KIND_S2L, 1903, 1, 1, 24'd0);
        send_item(KIND_L2S, 1901, 4, 29, 24'd0);
        send_item(KIND_L2S, 1901, 5, 30, 24'd0);
        send_item(KIND_L2S, 1901, 12, 30, 24'd0);
        send_item(KIND_L2S, 1902, 1, 30, 24'd0);
        send_item(KIND_L2S, 1902, 15, 1, 24'd0);
        send_item(KIND_L2S, 1903, 12, 29, 24'd0);
        send_item(KIND_SPARE, 1902, 3, 3, W_ALL);
    endtask

    // The top two years of the 12-bit range, including a result that would land in 4096.
    task automatic test_year_rollover();
        pause_until_drained();
        write_limits(4094, MAX_YEAR);
        send_item(KIND_LOAD, 4093, 1, 1, W_LATE);
        send_item(KIND_LOAD, 4094, 1, 1, W_LATE);
        send_item(KIND_LOAD, 4095, 1, 1, W_LATE);
        send_item(KIND_L2S, 4095, 12, 30, 24'd0);
        send_item(KIND_L2S, 4094, 12, 30, 24'd0);
        send_item(KIND_S2L, 4095, 1, 1, 24'd0);
        send_item(KIND_S2L, 4095, 12, 31, 24'd0);
    endtask

    task automatic test_random_traffic(input int first, input int last, input int win_lo,
                                       input int win_n, input int n_items);
        int          n;
        int          pick;
        int          y;
        int          m;
        int          d;
        int          fallback;
        logic [1:0]  kind;
        logic [23:0] word;
        pause_until_drained();
        write_limits(first, last);
        for (n = 0; n < win_n; n++)
            send_item(KIND_LOAD, win_lo + n, $urandom_range(15), $urandom_range(31),
                      ($urandom_range(3) != 0) ? plausible_year_word() : 24'($urandom));
        fallback = read_is_safe(win_lo) ? win_lo : win_lo + 1;
        for (n = 0; n < n_items; n++) begin
            if (n == n_items / 2) pause_until_drained();
            pick = $urandom_range(99);
            word = 24'($urandom);
            y = ($urandom_range(9) != 0) ? win_lo + $urandom_range(win_n - 1)
                                         : $urandom_range(MAX_YEAR);
            m = $urandom_range(1, 12);
            d = $urandom_range(1, 30);
            if (pick < 12) begin
                kind = KIND_LOAD;
                if ($urandom_range(3) != 0) word = plausible_year_word();
            end else if (pick < 52) begin
                kind = KIND_S2L;
                d = $urandom_range(1, days_in_month(y, m));
            end else if (pick < 92) begin
                kind = KIND_L2S;
            end else begin
                kind = KIND_SPARE;
            end
            if ($urandom_range(9) == 0) begin
                m = $urandom_range(15);
                d = $urandom_range(31);
            end
            if ($urandom_range(19) == 0) kind = 2'($urandom_range(3));
            if (kind != KIND_LOAD && !read_is_safe(y)) y = fallback;
            send_item(kind, y, m, d, word);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        src_idle_pct = 28;
        sink_idle_pct = 84;
        test_reset_limits();
        test_directed_cases();
        test_year_rollover();
        test_random_traffic(1901, 2099, 1901, 16, 200);

        src_idle_pct = 84;
        sink_idle_pct = 28;
        test_random_traffic(1, MAX_YEAR, 1, 12, 180);
        test_random_traffic(3840, MAX_YEAR, 4080, 16, 100);

        src_idle_pct = 0;
        sink_idle_pct = 0;
        test_random_traffic(2000, 2010, 2000, 16, 100);
        test_random_traffic(MAX_YEAR, 1, MAX_YEAR, 1, 20);

        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_dates.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
